>>> hw/rtl/imu_complementary_filter_core_macros.svh
// Assertion helpers shared by the filter RTL.
`ifndef IMU_COMPLEMENTARY_FILTER_CORE_MACROS_SVH
`define IMU_COMPLEMENTARY_FILTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ICF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ICF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/icf_pkg.sv
`default_nettype none

package icf_pkg;

    localparam int ANGLE_W    = 25;
    localparam int WORK_W     = 30;
    localparam int CORD_W     = 28;
    localparam int Z_W        = 26;
    localparam int MUL_A_W    = 26;
    localparam int MUL_B_W    = 17;
    localparam int PROD_W     = 43;
    localparam int SQ_W       = 48;
    localparam int ROOT_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic signed [WORK_W-1:0] DEG180 = 30'sd11796480;
    localparam logic signed [WORK_W-1:0] DEG360 = 30'sd23592960;
    localparam logic signed [Z_W-1:0]    DEG90  = 26'sd5898240;

    localparam logic [15:0] BLEND_WEIGHT_RST  = 16'd6554;
    localparam logic [15:0] SAMPLE_PERIOD_RST = 16'd328;
    localparam logic [23:0] ERROR_LIMIT_RST   = 24'd2949120;
    localparam logic [15:0] MIN_MAGNITUDE_RST = 16'd1638;

    localparam logic [CFG_IDX_W-1:0] REG_BLEND_WEIGHT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_MAGNITUDE = 3'd3;

    // Status of an iterative unit, seen by the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } icf_unit_sts_t;

    // atan(2^-i) in degrees Q.16, rounded to nearest.
    function automatic logic signed [Z_W-1:0] atan_lut(input logic [4:0] i);
        logic signed [Z_W-1:0] v;
        begin
            unique case (i)
                5'd0:    v = 26'sd2949120;
                5'd1:    v = 26'sd1740967;
                5'd2:    v = 26'sd919879;
                5'd3:    v = 26'sd466945;
                5'd4:    v = 26'sd234379;
                5'd5:    v = 26'sd117304;
                5'd6:    v = 26'sd58666;
                5'd7:    v = 26'sd29335;
                5'd8:    v = 26'sd14668;
                5'd9:    v = 26'sd7334;
                5'd10:   v = 26'sd3667;
                5'd11:   v = 26'sd1833;
                5'd12:   v = 26'sd917;
                5'd13:   v = 26'sd458;
                5'd14:   v = 26'sd229;
                5'd15:   v = 26'sd115;
                5'd16:   v = 26'sd57;
                5'd17:   v = 26'sd29;
                5'd18:   v = 26'sd14;
                5'd19:   v = 26'sd7;
                5'd20:   v = 26'sd4;
                5'd21:   v = 26'sd2;
                5'd22:   v = 26'sd1;
                default: v = 26'sd0;
            endcase
            return v;
        end
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/icf_cordic.sv
`default_nettype none

// Vectoring CORDIC, one micro-rotation per cycle.
module icf_cordic #(
    parameter int STEPS = 20
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic signed [icf_pkg::CORD_W-1:0]   y_in,
    input  wire logic signed [icf_pkg::CORD_W-1:0]   x_in,
    output logic signed [icf_pkg::Z_W-1:0]           z_out,
    output icf_pkg::icf_unit_sts_t                   sts
);

    localparam int CNT_W = $clog2(STEPS + 1);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(STEPS);

    logic signed [icf_pkg::CORD_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [icf_pkg::Z_W-1:0]    z_reg, z_next;
    logic [CNT_W-1:0]                  cnt_reg, cnt_next;
    logic                              busy_reg, busy_next, done_reg, done_next;
    logic signed [icf_pkg::CORD_W-1:0] xs, ys;
    logic [4:0]                        idx;

    always_comb
    begin
        idx       = 5'(cnt_reg);
        xs        = x_reg >>> idx;
        ys        = y_reg >>> idx;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            x_next    = x_in;
            y_next    = y_in;
            z_next    = '0;
            if (x_in == '0 && y_in == '0)
            begin
                // zero vector: skip the rotations, angle stays zero
                cnt_next = LAST;
            end
            else if (x_in < 0)
            begin
                // pre-rotate by 90 degrees toward the positive x axis
                if (y_in >= 0)
                begin
                    x_next = y_in;
                    y_next = -x_in;
                    z_next = icf_pkg::DEG90;
                end
                else
                begin
                    x_next = -y_in;
                    y_next = x_in;
                    z_next = -icf_pkg::DEG90;
                end
            end
        end
        else if (busy_reg)
        begin
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (y_reg >= 0)
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + icf_pkg::atan_lut(idx);
                end
                else
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - icf_pkg::atan_lut(idx);
                end
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign z_out    = z_reg;
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

`default_nettype wire

>>> hw/rtl/icf_isqrt.sv
`default_nettype none

// Integer square root, one result bit per cycle.
module icf_isqrt (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [icf_pkg::SQ_W-1:0]      n_in,
    output logic [icf_pkg::ROOT_W-1:0]         root,
    output icf_pkg::icf_unit_sts_t             sts
);

    logic [icf_pkg::SQ_W-1:0] n_reg, n_next, r_reg, r_next, bit_reg, bit_next, trial;
    logic                     busy_reg, busy_next, done_reg, done_next;

    always_comb
    begin
        trial     = r_reg + bit_reg;
        n_next    = n_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            n_next    = n_in;
            r_next    = '0;
            bit_next  = {2'b01, {(icf_pkg::SQ_W - 2){1'b0}}};
        end
        else if (busy_reg)
        begin
            if (bit_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                if (n_reg >= trial)
                begin
                    n_next = n_reg - trial;
                    r_next = (r_reg >> 1) + bit_reg;
                end
                else
                begin
                    r_next = r_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            bit_reg  <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        r_reg <= r_next;
    end

    assign root     = r_reg[icf_pkg::ROOT_W-1:0];
    assign sts.busy = busy_reg;
    assign sts.done = done_reg;

endmodule

`default_nettype wire

>>> hw/rtl/imu_complementary_filter_core.sv
// Complementary-filter attitude estimator, one IMU sample per input transaction.
// Input channel (in_valid / in_stall): six 16-bit fields, three accel axes and
// three gyro rates. in_stall stays high while a sample is being processed.
// Output channel (out_valid / out_stall): fused roll, pitch and gyro yaw in
// degrees Q.16; one output transaction per input transaction, held while stalled.
// Config channel (cfg_valid / cfg_ready): cfg_ready is always high; write only
// while idle. Unknown indexes are dropped.
// With the accel magnitude at or above the threshold, a sample passes through the
// shared multiplier pass, the 24-step square root, two CORDIC runs and the blend;
// below it, the square root and CORDIC runs are skipped. Each 360-degree correction
// of an angle adds a pass through the wrap state. The next sample is taken in the idle
// cycle after the result loads into the output register, so a new sample is never
// taken while the last one is in progress. A stalled output holds the block in its final
// state until the earlier result is taken.
// Reset clears the stored angles to zero, loads the register defaults and
// drops any pending result.
`default_nettype none

`include "imu_complementary_filter_core_macros.svh"

module imu_complementary_filter_core #(
    parameter int CORDIC_STEPS = 20
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire logic signed [15:0]                    accel_x,
    input  wire logic signed [15:0]                    accel_y,
    input  wire logic signed [15:0]                    accel_z,
    input  wire logic signed [15:0]                    rate_x,
    input  wire logic signed [15:0]                    rate_y,
    input  wire logic signed [15:0]                    rate_z,
    output logic                                       out_valid,
    input  wire logic                                  out_stall,
    output logic signed [icf_pkg::ANGLE_W-1:0]         roll_out,
    output logic signed [icf_pkg::ANGLE_W-1:0]         pitch_out,
    output logic signed [icf_pkg::ANGLE_W-1:0]         yaw_out,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [icf_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  wire logic [icf_pkg::CFG_DATA_W-1:0]        cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_MUL_TAKE, S_SQRT_GO, S_SQRT_WAIT, S_ROLL_GO, S_ROLL_WAIT,
        S_PITCH_GO, S_PITCH_WAIT, S_BLEND, S_BLEND_TAKE, S_WRAP, S_DONE
    } state_t;

    // Operations of the shared multiplier pass.
    typedef enum logic [2:0] {
        OP_AX, OP_AY, OP_AZ, OP_MIN, OP_GX, OP_GY, OP_GZ
    } op_t;

    localparam int W  = icf_pkg::WORK_W;
    localparam int PW = icf_pkg::PROD_W;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;
    logic [1:0] ch_reg, ch_next;

    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg, gy_reg, gz_reg;
    logic [15:0] blend_weight_reg, sample_period_reg, min_magnitude_reg;
    logic [23:0] error_limit_reg;

    logic signed [icf_pkg::ANGLE_W-1:0] est_reg [3];
    logic signed [icf_pkg::ANGLE_W-1:0] est_next [3];
    logic signed [W-1:0]  g_reg [3];
    logic signed [W-1:0]  g_next [3];
    logic signed [icf_pkg::Z_W-1:0] acc_reg [2];
    logic signed [icf_pkg::Z_W-1:0] acc_next [2];

    logic [32:0] mag_reg, mag_next;
    logic [31:0] yz_reg, yz_next, min2_reg, min2_next;
    logic [icf_pkg::ROOT_W-1:0] root_reg, root_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [W-1:0]  wv_reg, wv_next;

    logic signed [icf_pkg::ANGLE_W-1:0] roll_reg, pitch_reg, yaw_reg;
    logic out_valid_reg, out_valid_next, out_load;
    logic roll_in_range, yaw_in_range;

    logic signed [icf_pkg::MUL_A_W-1:0] mul_a;
    logic signed [icf_pkg::MUL_B_W-1:0] mul_b;
    logic signed [W-1:0] err, err_c, lim, g_sel;
    logic signed [PW-1:0] delta, rnd;
    logic in_take;

    logic sqrt_start, cordic_start;
    logic [icf_pkg::ROOT_W-1:0] sqrt_root;
    logic signed [icf_pkg::CORD_W-1:0] cord_y, cord_x;
    logic signed [icf_pkg::Z_W-1:0] cord_z;
    icf_pkg::icf_unit_sts_t sqrt_sts, cord_sts;

    // Square root of (ay^2 + az^2) << 16 for the pitch denominator.
    icf_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .n_in  ({yz_reg, 16'b0}),
        .root  (sqrt_root),
        .sts   (sqrt_sts)
    );

    // One CORDIC shared by roll and pitch.
    icf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .y_in  (cord_y),
        .x_in  (cord_x),
        .z_out (cord_z),
        .sts   (cord_sts)
    );

    assign in_stall     = (state_reg != S_IDLE);
    assign in_take      = in_valid && !in_stall;
    assign cfg_ready    = 1'b1;
    assign sqrt_start   = (state_reg == S_SQRT_GO);
    assign cordic_start = (state_reg == S_ROLL_GO) || (state_reg == S_PITCH_GO);

    // Roll: atan2(ay, az); pitch: atan2(-ax, root), all scaled by 256.
    always_comb
    begin
        if (state_reg == S_PITCH_GO)
        begin
            cord_y = -(icf_pkg::CORD_W'(ax_reg) <<< 8);
            cord_x = icf_pkg::CORD_W'({1'b0, root_reg});
        end
        else
        begin
            cord_y = icf_pkg::CORD_W'(ay_reg) <<< 8;
            cord_x = icf_pkg::CORD_W'(az_reg) <<< 8;
        end
    end

    // Clamp the accel minus gyro error to the error limit.
    always_comb
    begin
        g_sel = g_reg[ch_reg];
        lim   = W'({1'b0, error_limit_reg});
        err   = W'(acc_reg[ch_reg[0]]) - g_sel;
        err_c = err;
        if (err > lim)
        begin
            err_c = lim;
        end
        if (err < -lim)
        begin
            err_c = -lim;
        end
    end

    // Shared multiplier operand select.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == S_BLEND)
        begin
            mul_a = icf_pkg::MUL_A_W'(err_c);
            mul_b = {1'b0, blend_weight_reg};
        end
        else
        begin
            unique case (op_reg)
                OP_AX:
                begin
                    mul_a = icf_pkg::MUL_A_W'(ax_reg);
                    mul_b = icf_pkg::MUL_B_W'(ax_reg);
                end
                OP_AY:
                begin
                    mul_a = icf_pkg::MUL_A_W'(ay_reg);
                    mul_b = icf_pkg::MUL_B_W'(ay_reg);
                end
                OP_AZ:
                begin
                    mul_a = icf_pkg::MUL_A_W'(az_reg);
                    mul_b = icf_pkg::MUL_B_W'(az_reg);
                end
                OP_MIN:
                begin
                    mul_a = {10'b0, min_magnitude_reg};
                    mul_b = {1'b0, min_magnitude_reg};
                end
                OP_GX:
                begin
                    mul_a = icf_pkg::MUL_A_W'(gx_reg);
                    mul_b = {1'b0, sample_period_reg};
                end
                OP_GY:
                begin
                    mul_a = icf_pkg::MUL_A_W'(gy_reg);
                    mul_b = {1'b0, sample_period_reg};
                end
                OP_GZ:
                begin
                    mul_a = icf_pkg::MUL_A_W'(gz_reg);
                    mul_b = {1'b0, sample_period_reg};
                end
                default:
                begin
                    mul_a = '0;
                    mul_b = '0;
                end
            endcase
        end
    end

    // Sequencer next-state and datapath.
    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        ch_next     = ch_reg;
        mag_next    = mag_reg;
        yz_next     = yz_reg;
        min2_next   = min2_reg;
        root_next   = root_reg;
        prod_next   = prod_reg;
        wv_next     = wv_reg;
        for (int k = 0; k < 3; k++)
        begin
            est_next[k] = est_reg[k];
            g_next[k]   = g_reg[k];
        end
        acc_next[0] = acc_reg[0];
        acc_next[1] = acc_reg[1];
        delta = (prod_reg + 43'sd8) >>> 4;
        rnd   = (prod_reg + 43'sd32768) >>> 16;
        out_load = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    op_next    = OP_AX;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_MUL_TAKE;
            end
            S_MUL_TAKE:
            begin
                state_next = S_MUL;
                op_next    = op_t'(op_reg + 3'd1);
                unique case (op_reg)
                    OP_AX: mag_next = 33'(prod_reg[31:0]);
                    OP_AY:
                    begin
                        yz_next  = prod_reg[31:0];
                        mag_next = mag_reg + 33'(prod_reg[31:0]);
                    end
                    OP_AZ:
                    begin
                        yz_next  = yz_reg + prod_reg[31:0];
                        mag_next = mag_reg + 33'(prod_reg[31:0]);
                    end
                    OP_MIN: min2_next = prod_reg[31:0];
                    OP_GX: g_next[0] = W'(est_reg[0]) + W'(delta);
                    OP_GY: g_next[1] = W'(est_reg[1]) + W'(delta);
                    OP_GZ:
                    begin
                        g_next[2] = W'(est_reg[2]) + W'(delta);
                        op_next   = OP_AX;
                        ch_next   = 2'd0;
                        if (mag_reg >= {1'b0, min2_reg})
                        begin
                            state_next = S_SQRT_GO;
                        end
                        else
                        begin
                            acc_next[0] = '0;
                            acc_next[1] = '0;
                            state_next  = S_BLEND;
                        end
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_SQRT_GO: state_next = S_SQRT_WAIT;
            S_SQRT_WAIT:
            begin
                if (sqrt_sts.done)
                begin
                    root_next  = sqrt_root;
                    state_next = S_ROLL_GO;
                end
            end
            S_ROLL_GO: state_next = S_ROLL_WAIT;
            S_ROLL_WAIT:
            begin
                if (cord_sts.done)
                begin
                    acc_next[0] = cord_z;
                    state_next  = S_PITCH_GO;
                end
            end
            S_PITCH_GO: state_next = S_PITCH_WAIT;
            S_PITCH_WAIT:
            begin
                if (cord_sts.done)
                begin
                    acc_next[1] = cord_z;
                    state_next  = S_BLEND;
                end
            end
            S_BLEND:
            begin
                if (ch_reg == 2'd2)
                begin
                    // yaw takes the gyro integral alone
                    wv_next    = g_sel;
                    state_next = S_WRAP;
                end
                else
                begin
                    prod_next  = mul_a * mul_b;
                    state_next = S_BLEND_TAKE;
                end
            end
            S_BLEND_TAKE:
            begin
                wv_next    = g_sel + W'(rnd);
                state_next = S_WRAP;
            end
            S_WRAP:
            begin
                if (wv_reg > icf_pkg::DEG180)
                begin
                    wv_next = wv_reg - icf_pkg::DEG360;
                end
                else if (wv_reg < -icf_pkg::DEG180)
                begin
                    wv_next = wv_reg + icf_pkg::DEG360;
                end
                else
                begin
                    est_next[ch_reg] = wv_reg[icf_pkg::ANGLE_W-1:0];
                    if (ch_reg == 2'd2)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = S_BLEND;
                    end
                end
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        out_valid_next = out_load ? 1'b1 : (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            op_reg            <= OP_AX;
            ch_reg            <= 2'd0;
            out_valid_reg     <= 1'b0;
            blend_weight_reg  <= icf_pkg::BLEND_WEIGHT_RST;
            sample_period_reg <= icf_pkg::SAMPLE_PERIOD_RST;
            error_limit_reg   <= icf_pkg::ERROR_LIMIT_RST;
            min_magnitude_reg <= icf_pkg::MIN_MAGNITUDE_RST;
            for (int k = 0; k < 3; k++)
            begin
                est_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            ch_reg        <= ch_next;
            out_valid_reg <= out_valid_next;
            for (int k = 0; k < 3; k++)
            begin
                est_reg[k] <= est_next[k];
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    icf_pkg::REG_BLEND_WEIGHT:  blend_weight_reg  <= cfg_data[15:0];
                    icf_pkg::REG_SAMPLE_PERIOD: sample_period_reg <= cfg_data[15:0];
                    icf_pkg::REG_ERROR_LIMIT:   error_limit_reg   <= cfg_data;
                    icf_pkg::REG_MIN_MAGNITUDE: min_magnitude_reg <= cfg_data[15:0];
                    default:                    ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            az_reg <= accel_z;
            gx_reg <= rate_x;
            gy_reg <= rate_y;
            gz_reg <= rate_z;
        end
        if (out_load)
        begin
            roll_reg  <= est_reg[0];
            pitch_reg <= est_reg[1];
            yaw_reg   <= est_reg[2];
        end
        mag_reg   <= mag_next;
        yz_reg    <= yz_next;
        min2_reg  <= min2_next;
        root_reg  <= root_next;
        prod_reg  <= prod_next;
        wv_reg    <= wv_next;
        for (int k = 0; k < 3; k++)
        begin
            g_reg[k] <= g_next[k];
        end
        acc_reg[0] <= acc_next[0];
        acc_reg[1] <= acc_next[1];
    end

    assign out_valid = out_valid_reg;
    assign roll_out  = roll_reg;
    assign pitch_out = pitch_reg;
    assign yaw_out   = yaw_reg;

    assign roll_in_range = (roll_reg <= icf_pkg::DEG180) && (roll_reg >= -icf_pkg::DEG180);
    assign yaw_in_range  = (yaw_reg <= icf_pkg::DEG180) && (yaw_reg >= -icf_pkg::DEG180);

    `ICF_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_take, in_stall, "no stall after take")
    `ICF_ASSERT_NOW(a_roll_range, clk, rst_n, out_valid_reg, roll_in_range, "roll out of range")
    `ICF_ASSERT_NOW(a_yaw_range, clk, rst_n, out_valid_reg, yaw_in_range, "yaw out of range")
    `ICF_ASSERT_NOW(a_units_apart, clk, rst_n, 1'b1, !(sqrt_sts.busy && cord_sts.busy), "overlap")

endmodule

`default_nettype wire

>>> tb/imu_complementary_filter_core_test.sv
`default_nettype none

module imu_complementary_filter_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TB_CORDIC_STEPS = 20;
    localparam int IDLE_LIMIT      = 20000;  // cycles with no transaction at all
    localparam int LONG_HOLD       = 3000;   // receiver hold-off length
    localparam int TAIL_CYCLES     = 200;

    // Register index that decodes to nothing.
    localparam logic [icf_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 3'd5;

    // One IMU sample as offered on the input channel.
    typedef struct {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] gx;
        logic signed [15:0] gy;
        logic signed [15:0] gz;
    } imu_sample_t;

    // Fused attitude of one output transaction.
    typedef struct {
        logic signed [icf_pkg::ANGLE_W-1:0] roll;
        logic signed [icf_pkg::ANGLE_W-1:0] pitch;
        logic signed [icf_pkg::ANGLE_W-1:0] yaw;
    } attitude_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                                in_valid = 1'b0;
    logic                                in_stall;
    logic signed [15:0]                  accel_x = '0;
    logic signed [15:0]                  accel_y = '0;
    logic signed [15:0]                  accel_z = '0;
    logic signed [15:0]                  rate_x = '0;
    logic signed [15:0]                  rate_y = '0;
    logic signed [15:0]                  rate_z = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    logic signed [icf_pkg::ANGLE_W-1:0]  roll_out;
    logic signed [icf_pkg::ANGLE_W-1:0]  pitch_out;
    logic signed [icf_pkg::ANGLE_W-1:0]  yaw_out;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [icf_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [icf_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

    imu_complementary_filter_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .accel_z   (accel_z),
        .rate_x    (rate_x),
        .rate_y    (rate_y),
        .rate_z    (rate_z),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .roll_out  (roll_out),
        .pitch_out (pitch_out),
        .yaw_out   (yaw_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Attitude predictor: private copy of the registers and stored angles.
    // ------------------------------------------------------------------
    longint alpha_q16   = icf_pkg::BLEND_WEIGHT_RST;
    longint dt_q16      = icf_pkg::SAMPLE_PERIOD_RST;
    longint err_clamp   = icf_pkg::ERROR_LIMIT_RST;
    longint mag_floor   = icf_pkg::MIN_MAGNITUDE_RST;
    longint roll_st     = 0;
    longint pitch_st    = 0;
    longint yaw_st      = 0;

    localparam longint ATAN_STEP [32] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0
    };
    localparam longint HALF_TURN = 180 * 65536;
    localparam longint FULL_TURN = 360 * 65536;
    localparam longint QUARTER   = 90 * 65536;

    function automatic longint floor_root(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z;
        longint t;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        // Rotate a left half-plane vector by a quarter turn first.
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                z = QUARTER;
            end
            else
            begin
                x = -y;
                y = t;
                z = -QUARTER;
            end
        end
        for (int i = 0; i < TB_CORDIC_STEPS && i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_STEP[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_STEP[i];
            end
        end
        return z;
    endfunction

    function automatic longint wrap_half_turn(longint v);
        if (v > HALF_TURN)
            v = v - FULL_TURN * ((v - HALF_TURN + FULL_TURN - 1) / FULL_TURN);
        if (v < -HALF_TURN)
            v = v + FULL_TURN * ((-HALF_TURN - v + FULL_TURN - 1) / FULL_TURN);
        return v;
    endfunction

    function automatic longint fuse_angle(longint acc, longint gyro);
        longint e;
        e = acc - gyro;
        if (e > err_clamp)
            e = err_clamp;
        if (e < -err_clamp)
            e = -err_clamp;
        return wrap_half_turn(gyro + ((alpha_q16 * e + 32768) >>> 16));
    endfunction

    // Advance the stored angles by one sample and return the new attitude.
    function automatic attitude_t fuse_sample(imu_sample_t s);
        attitude_t a;
        longint ax, ay, az;
        longint yz2, mag2;
        longint accel_roll, accel_pitch;
        ax = s.ax;
        ay = s.ay;
        az = s.az;
        accel_roll = 0;
        accel_pitch = 0;
        yz2 = ay * ay + az * az;
        mag2 = yz2 + ax * ax;
        if (mag2 >= mag_floor * mag_floor)
        begin
            accel_roll = vector_angle(ay * 256, az * 256);
            accel_pitch = vector_angle(-ax * 256, floor_root(longint'(yz2) << 16));
        end
        roll_st = fuse_angle(accel_roll, roll_st + ((longint'(s.gx) * dt_q16 + 8) >>> 4));
        pitch_st = fuse_angle(accel_pitch, pitch_st + ((longint'(s.gy) * dt_q16 + 8) >>> 4));
        yaw_st = wrap_half_turn(yaw_st + ((longint'(s.gz) * dt_q16 + 8) >>> 4));
        a.roll = roll_st[icf_pkg::ANGLE_W-1:0];
        a.pitch = pitch_st[icf_pkg::ANGLE_W-1:0];
        a.yaw = yaw_st[icf_pkg::ANGLE_W-1:0];
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Queues and counters
    // ------------------------------------------------------------------
    imu_sample_t sample_q[$];      // samples not yet offered
    attitude_t   attitude_q[$];    // predicted attitudes, oldest first
    imu_sample_t offered;
    int          mismatches = 0;
    int          samples_taken = 0;
    int          attitudes_seen = 0;
    int          reg_writes = 0;
    int          idle_cycles = 0;
    int          burst_left = 0;
    int          gap_left = 0;

    // ------------------------------------------------------------------
    // Driver: offer samples in bursts, hold a stalled transaction steady.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic taken;
        taken = rst_n && in_valid && !in_stall;
        if (taken)
        begin
            attitude_q.push_back(fuse_sample(offered));
            samples_taken++;
        end
        if (rst_n && !(in_valid && in_stall))
        begin
            // Slot is free: either idle through a gap or offer the next sample.
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (sample_q.size() > 0)
            begin
                offered = sample_q.pop_front();
                in_valid <= 1'b1;
                accel_x <= offered.ax;
                accel_y <= offered.ay;
                accel_z <= offered.az;
                rate_x <= offered.gx;
                rate_y <= offered.gy;
                rate_z <= offered.gz;
                if (burst_left > 0)
                    burst_left--;
                else
                begin
                    burst_left = $urandom_range(0, 8);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: stall pattern plus one long hold-off, compare attitudes.
    // ------------------------------------------------------------------
    int stall_mode = 0;
    int mode_cycles = 0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    always @(posedge clk)
    begin
        attitude_t exp_att;
        if (rst_n && out_valid && !out_stall)
        begin
            attitudes_seen++;
            if (attitude_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected attitude roll %0d pitch %0d yaw %0d",
                             roll_out, pitch_out, yaw_out);
            end
            else
            begin
                exp_att = attitude_q.pop_front();
                if (roll_out !== exp_att.roll || pitch_out !== exp_att.pitch ||
                    yaw_out !== exp_att.yaw)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("attitude %0d: expected %0d/%0d/%0d got %0d/%0d/%0d",
                                 attitudes_seen, exp_att.roll, exp_att.pitch,
                                 exp_att.yaw, roll_out, pitch_out, yaw_out);
                end
            end
        end
        // Start the long hold-off once, well into the run.
        if (!hold_done && attitudes_seen == 60)
        begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (mode_cycles == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            mode_cycles = $urandom_range(50, 300);
        end
        else
            mode_cycles--;
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_mode == 0)
            out_stall <= 1'b0;
        else if (stall_mode == 1)
            out_stall <= ($urandom_range(0, 3) == 0);
        else
            out_stall <= ($urandom_range(0, 3) != 0);
    end

    // Watchdog: end the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
            $display("imu_complementary_filter_core test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [icf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [icf_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        // Mirror the write; unknown indexes are dropped.
        case (idx)
            icf_pkg::REG_BLEND_WEIGHT:  alpha_q16 = val[15:0];
            icf_pkg::REG_SAMPLE_PERIOD: dt_q16 = val[15:0];
            icf_pkg::REG_ERROR_LIMIT:   err_clamp = val[23:0];
            icf_pkg::REG_MIN_MAGNITUDE: mag_floor = val[15:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [15:0] bw, input logic [15:0] sp,
                             input logic [23:0] el, input logic [15:0] mm);
        write_reg(icf_pkg::REG_BLEND_WEIGHT, {8'h00, bw});
        write_reg(icf_pkg::REG_SAMPLE_PERIOD, {8'h00, sp});
        write_reg(icf_pkg::REG_ERROR_LIMIT, el);
        write_reg(icf_pkg::REG_MIN_MAGNITUDE, {8'h00, mm});
    endtask

    // Wait until every sample is taken and every attitude has come back.
    task automatic drain;
        while (sample_q.size() > 0 || in_valid || attitude_q.size() > 0)
            @(posedge clk);
    endtask

    function automatic logic signed [15:0] around(int span);
        return 16'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic add_sample(input int ax, input int ay, input int az,
                              input int gx, input int gy, input int gz);
        imu_sample_t s;
        s.ax = 16'(ax);
        s.ay = 16'(ay);
        s.az = 16'(az);
        s.gx = 16'(gx);
        s.gy = 16'(gy);
        s.gz = 16'(gz);
        sample_q.push_back(s);
    endtask

    task automatic add_random_samples(input int n);
        imu_sample_t s;
        int g;
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    // Noise: every bit free.
                    s.ax = 16'($urandom);
                    s.ay = 16'($urandom);
                    s.az = 16'($urandom);
                    s.gx = 16'($urandom);
                    s.gy = 16'($urandom);
                    s.gz = 16'($urandom);
                end
                2:
                begin
                    // Near free fall: magnitude around the threshold.
                    s.ax = around(1200);
                    s.ay = around(1200);
                    s.az = around(1200);
                    s.gx = around(400);
                    s.gy = around(400);
                    s.gz = around(400);
                end
                default:
                begin
                    // Plausible motion: gravity-sized accel, modest rates.
                    g = $urandom_range(2000, 20000);
                    s.ax = around(g);
                    s.ay = around(g);
                    s.az = around(g);
                    s.gx = around(1600);
                    s.gy = around(1600);
                    s.gz = around(1600);
                end
            endcase
            sample_q.push_back(s);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset defaults: axis extremes, all quadrants, below the threshold.
        add_sample(0, 0, 16384, 0, 0, 0);
        add_sample(32767, 32767, 32767, 32767, 32767, 32767);
        add_sample(-32768, -32768, -32768, -32768, -32768, -32768);
        add_sample(0, 5000, -16384, 100, -100, 50);
        add_sample(0, -5000, -16384, -100, 100, -50);
        add_sample(-16384, 0, 0, 0, 0, 0);
        add_sample(16384, 0, 0, 0, 0, 0);
        add_sample(10, -20, 30, 16, -16, 16);
        add_sample(1637, 0, 0, 0, 0, 0);
        add_sample(1638, 0, 0, 0, 0, 0);
        drain();

        // Full weight, largest step and an out-of-range clamp; zero threshold
        // lets the zero vector through. An unknown index must be dropped.
        write_all(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 16'h0000);
        write_reg(REG_UNMAPPED, 24'h00ABCD);
        add_sample(0, 0, 0, 0, 0, 0);
        add_sample(0, 0, 0, 32767, -32768, 32767);
        add_sample(32767, -32768, 32767, 32767, 32767, -32768);
        add_sample(-32768, 32767, -32768, -32768, 32767, 32767);
        add_sample(0, 0, 0, 0, 0, 0);
        add_sample(1, 0, 0, 0, 0, 0);
        drain();

        // Zero weight and step, zero clamp, threshold near the largest accel magnitude.
        write_all(16'h0000, 16'h0000, 24'h000000, 16'd56755);
        add_sample(32767, 32767, 32767, 1000, 1000, 1000);
        add_sample(-32768, -32768, -32768, -1000, -1000, -1000);
        add_sample(1000, 2000, -3000, 0, 0, 0);
        drain();

        // Random settings, with one extreme setting in the last pass.
        for (int p = 0; p < 4; p++)
        begin
            if (p == 3)
                write_all(16'hFFFF, 16'd20000, 24'd11796480, 16'd1638);
            else
                write_all(16'($urandom), 16'($urandom_range(0, 4000)),
                          24'($urandom_range(0, 11796480)), 16'($urandom_range(0, 4000)));
            add_random_samples(105);
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("covered %0d samples, %0d attitudes, %0d register writes, long hold-off %0s",
                 samples_taken, attitudes_seen, reg_writes, hold_done ? "done" : "missed");
        $display("%0d mismatches", mismatches);
        if (mismatches == 0 && attitude_q.size() == 0)
            $display("imu_complementary_filter_core test passed");
        else
            $display("imu_complementary_filter_core test failed");
        $finish;
    end

endmodule

`default_nettype wire
